// ===== rtl/swmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_pkg: shared types and constants for the sliding window min/max block
// Sizes of the deque chains, sample and position formats, cell control word.
// ----------------------------------------------------------------------------
package swmm_pkg;

  // Deepest window supported, and thus the number of cells in each chain
  localparam int unsigned MAX_WINDOW  = 1024;
  // Sample width (two's complement)
  localparam int unsigned SAMPLE_BITS = 32;
  // Positions count modulo twice the deepest window
  localparam int unsigned POS_BITS    = $clog2(2 * MAX_WINDOW);
  // Width of the window length register
  localparam int unsigned LEN_BITS    = 11;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [POS_BITS-1:0]           pos_t;
  typedef logic [LEN_BITS-1:0]           len_t;

  // One deque entry as handed between neighbor cells
  typedef struct packed {
    logic    valid;
    sample_t value;
    pos_t    pos;
  } entry_t;

  // Control word broadcast to every cell of a chain
  typedef struct packed {
    logic    push;    // a sample joins this cycle
    logic    shift;   // drop the front entry, every cell takes its right neighbor
    logic    clr;     // new run: forget all entries
    logic    is_max;  // chain keeps the maximum (else the minimum)
    sample_t sample;  // incoming sample
    pos_t    now;     // position of the incoming sample
  } cell_op_t;

endpackage

// ===== rtl/swmm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_cell: one slot of a monotonic deque chain
// Holds one entry, pops it when the incoming sample beats it, takes the new
// sample when it is the first free slot, and takes its right neighbor on shift.
// ----------------------------------------------------------------------------
module swmm_cell
  import swmm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cell_op_t op_i,
  input  logic     left_keep_i,   // left neighbor survives the push
  input  entry_t   right_i,       // right neighbor's entry
  input  logic     right_keep_i,  // right neighbor survives the push
  output entry_t   entry_o,
  output logic     keep_o
);

  logic    valid_q, valid_d;
  sample_t value_q, value_d;
  pos_t    pos_q, pos_d;
  logic    beaten;

  // Strictly beaten entries leave the tail; ties stay
  assign beaten  = op_i.is_max ? (op_i.sample > value_q) : (op_i.sample < value_q);
  assign keep_o  = valid_q & ~op_i.clr & ~beaten;
  assign entry_o = '{valid: valid_q, value: value_q, pos: pos_q};

  // Select the next entry of this slot
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    pos_d   = pos_q;
    if (op_i.push) begin
      if (op_i.shift) begin
        if (right_keep_i) begin
          valid_d = 1'b1;
          value_d = right_i.value;
          pos_d   = right_i.pos;
        end else if (keep_o) begin
          valid_d = 1'b1;
          value_d = op_i.sample;
          pos_d   = op_i.now;
        end else begin
          valid_d = 1'b0;
        end
      end else if (!keep_o) begin
        if (left_keep_i) begin
          valid_d = 1'b1;
          value_d = op_i.sample;
          pos_d   = op_i.now;
        end else begin
          valid_d = 1'b0;
        end
      end
    end else if (op_i.shift) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
      pos_d   = right_i.pos;
    end
  end

  // Hold the valid flag under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pos_q   <= pos_d;
  end

endmodule

// ===== rtl/swmm_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_chain: monotonic deque built as a row of cells
// Cell 0 is the deque front. Checks the front two entries for age, drives the
// shift and push control, and predicts the front value after a push.
// ----------------------------------------------------------------------------
module swmm_chain
  import swmm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,     // a sample joins this cycle
  input  logic    pend_i,     // a sample waits at the input
  input  logic    clr_i,      // the sample starts a new run
  input  logic    is_max_i,   // keep the maximum instead of the minimum
  input  sample_t sample_i,
  input  pos_t    now_i,      // position given to the joining sample
  input  pos_t    age_ref_i,  // position of the next sample, for age checks
  input  len_t    len_i,      // effective window length
  output sample_t front_d_o,  // front value after this cycle's push
  output logic    hold_o      // two stale front entries: no push this cycle
);

  entry_t   ent  [MAX_WINDOW+1];
  logic     keep [MAX_WINDOW+1];
  cell_op_t op;
  pos_t     age0, age1;
  logic     stale0, stale1;
  logic     front_beaten, front_keep;

  // Dummy neighbor right of the last cell
  assign ent[MAX_WINDOW]  = '0;
  assign keep[MAX_WINDOW] = 1'b0;

  // Age of the front two entries
  assign age0   = age_ref_i - ent[0].pos;
  assign age1   = age_ref_i - ent[1].pos;
  assign stale0 = ent[0].valid & (age0 >= POS_BITS'(len_i));
  assign stale1 = ent[1].valid & (age1 >= POS_BITS'(len_i));
  assign hold_o = stale0 & stale1;

  // Front entry survives the push, taken straight from the front entry
  assign front_beaten = is_max_i ? (sample_i > ent[0].value) : (sample_i < ent[0].value);
  assign front_keep   = ent[0].valid & ~clr_i & ~front_beaten;

  // Broadcast control: drop a stale front unless the push empties the deque;
  // without a push, drop only while a held sample waits for the front to clear
  always_comb begin
    op.push   = push_i;
    op.clr    = clr_i;
    op.is_max = is_max_i;
    op.sample = sample_i;
    op.now    = now_i;
    op.shift  = stale0 & (push_i ? front_keep : (stale1 & pend_i));
  end

  // Front value after a push
  always_comb begin
    priority if (!keep[0]) begin
      front_d_o = sample_i;
    end else if (op.shift) begin
      front_d_o = keep[1] ? ent[1].value : sample_i;
    end else begin
      front_d_o = ent[0].value;
    end
  end

  // Row of cells
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic left_keep;
    if (k == 0) begin : g_front
      assign left_keep = 1'b1;
    end else begin : g_inner
      assign left_keep = keep[k-1];
    end
    swmm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .left_keep_i (left_keep),
      .right_i     (ent[k+1]),
      .right_keep_i(keep[k+1]),
      .entry_o     (ent[k]),
      .keep_o      (keep[k])
    );
  end

  // Checks
  a_no_push_on_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_o |-> !push_i) else $error("push while two front entries are stale");
  a_front_after_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |=> ent[0].valid) else $error("deque empty after push");
  a_packed_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent[1].valid |-> ent[0].valid) else $error("gap at deque front");

endmodule

// ===== rtl/sliding_window_min_max.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_min_max: running minimum and maximum over a sliding window
// Streaming signed samples in, window minimum and maximum out.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: tdata = sample, tuser = new run flag. A set flag forgets all
//   earlier samples and starts a new run with this one.
//   Output word: tdata = {window_max, window_min}, one word per input word
//   once the run holds window_len samples; no word before that.
//   window_len is written through cfg_we_i / cfg_wdata_i while the stream is
//   idle. A length of 0 acts as 1, one above 1024 acts as 1024.
// Timing and throughput:
//   The result word is registered and appears in the cycle after its sample is taken. One sample
//   is taken per cycle; after the window is shortened, input waits while two
//   or more expired entries sit at the front of either deque, and while a
//   sample waits each such deque drops one expired front entry per cycle.
// Reset: both deques empty, window length 1, new run.
// Stall: the output register holds its word while m_axis_tready is low; a new
//   sample is taken only when the output register is free or being emptied.
// ----------------------------------------------------------------------------
module sliding_window_min_max
  import swmm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [LEN_BITS-1:0]      cfg_wdata_i,    // window_len
  // sample stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [SAMPLE_BITS-1:0]   s_axis_tdata,   // [31:0] sample
  input  logic                     s_axis_tuser,   // [0] new_run
  // result stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [2*SAMPLE_BITS-1:0] m_axis_tdata    // [31:0] window_min, [63:32] window_max
);

  localparam len_t MaxLen = LEN_BITS'(MAX_WINDOW);

  len_t    window_len_q;
  len_t    len_eff;
  pos_t    pos_q, pos_d, now;
  len_t    fill_q, fill_d, fill_base;
  logic    out_valid_q;
  sample_t out_min_q, out_max_q;
  sample_t min_front_d, max_front_d;
  logic    min_hold, max_hold;
  logic    out_ok, accept, clr, emit;

  // Clamp the window length
  always_comb begin
    priority if (window_len_q == '0) begin
      len_eff = len_t'(1);
    end else if (window_len_q > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = window_len_q;
    end
  end

  // Input handshake
  assign out_ok        = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = out_ok & ~min_hold & ~max_hold;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign clr           = accept & s_axis_tuser;

  // Advance position and fill count
  assign now       = clr ? '0 : pos_q;
  assign pos_d     = now + pos_t'(1);
  assign fill_base = clr ? '0 : fill_q;
  assign fill_d    = (fill_base < MaxLen) ? fill_base + len_t'(1) : fill_base;
  assign emit      = fill_d >= len_eff;

  // Deques
  swmm_chain u_min_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .pend_i   (s_axis_tvalid),
    .clr_i    (clr),
    .is_max_i (1'b0),
    .sample_i (s_axis_tdata),
    .now_i    (now),
    .age_ref_i(pos_q),
    .len_i    (len_eff),
    .front_d_o(min_front_d),
    .hold_o   (min_hold)
  );

  swmm_chain u_max_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .pend_i   (s_axis_tvalid),
    .clr_i    (clr),
    .is_max_i (1'b1),
    .sample_i (s_axis_tdata),
    .now_i    (now),
    .age_ref_i(pos_q),
    .len_i    (len_eff),
    .front_d_o(max_front_d),
    .hold_o   (max_hold)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= len_t'(1);
      pos_q        <= '0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_len_q <= cfg_wdata_i;
      end
      if (accept) begin
        pos_q  <= pos_d;
        fill_q <= fill_d;
      end
      if (accept && emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_min_q <= min_front_d;
      out_max_q <= max_front_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_max_q, out_min_q};

  // Checks
  a_min_le_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_min_q <= out_max_q)) else $error("window min above max");
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= MaxLen) else $error("fill count above window depth");
  a_first_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clr && len_eff != len_t'(1)) |=> !out_valid_q)
    else $error("result before window filled");

endmodule

// ===== tb/tb_sliding_window_min_max.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_min_max: self-checking bench for the window min/max block
// Streams signed samples through the block under random source gaps and sink
// stalls. A local pair of monotonic deques predicts every min/max result,
// and each result word is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_sliding_window_min_max;
  import swmm_pkg::*;

  localparam int unsigned GAP_MAX       = 11;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam sample_t     SAMPLE_MIN    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam sample_t     SAMPLE_MAX    = ~SAMPLE_MIN;

  typedef enum logic [1:0] {
    ITEM_SAMPLE  = 2'd0,
    ITEM_SET_LEN = 2'd1,
    ITEM_DRAIN   = 2'd2
  } stim_kind_e;

  typedef enum logic [2:0] {
    STY_WIDE    = 3'd0,
    STY_NARROW  = 3'd1,
    STY_RISE    = 3'd2,
    STY_FALL    = 3'd3,
    STY_EXTREME = 3'd4
  } sample_style_e;

  typedef struct {
    stim_kind_e kind;
    sample_t    sample;
    logic       fresh;
    len_t       len;
  } stim_t;

  typedef struct {
    sample_t value;
    pos_t    pos;
  } deque_entry_t;

  typedef struct {
    sample_t win_min;
    sample_t win_max;
  } window_pair_t;

  // Clock, reset and block ports
  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  len_t                     cfg_wdata_i   = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [SAMPLE_BITS-1:0]   s_axis_tdata  = '0;   // [31:0] sample
  logic                     s_axis_tuser  = 1'b0; // [0] new_run
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [2*SAMPLE_BITS-1:0] m_axis_tdata;         // [31:0] window_min, [63:32] window_max

  // Stimulus and prediction state
  stim_t          pending[$];
  window_pair_t   expected_windows[$];
  deque_entry_t   low_chain[$];
  deque_entry_t   high_chain[$];
  len_t           window_reg = 11'd1;
  pos_t           next_pos   = '0;
  int unsigned    run_fill   = 0;
  sample_t        ramp       = '0;

  // Driver and monitor bookkeeping
  int unsigned    gap_left, stall_left, quiet;
  bit             send_calm, recv_calm;
  logic           nxt_valid, nxt_user, nxt_we, nxt_ready;
  sample_t        nxt_data;
  len_t           nxt_wdata;
  window_pair_t   want;
  sample_t        got_min, got_max;
  int unsigned    mismatches, samples_sent, fresh_runs, windows_checked, len_writes;

  sliding_window_min_max dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Advance the window by one sample and record the result it produces
  task automatic advance_window(input sample_t smp, input logic fresh);
    int unsigned span;
    pos_t        now;
    span = (window_reg == '0) ? 1 : ((window_reg > MAX_WINDOW) ? MAX_WINDOW : window_reg);
    if (fresh) begin
      low_chain.delete();
      high_chain.delete();
      next_pos = '0;
      run_fill = 0;
    end
    now = next_pos;
    // drop fronts that have aged out; ages wrap with the position width
    while (low_chain.size() > 0 && pos_t'(now - low_chain[0].pos) >= span)
      void'(low_chain.pop_front());
    while (high_chain.size() > 0 && pos_t'(now - high_chain[0].pos) >= span)
      void'(high_chain.pop_front());
    // drop tails the new sample beats; ties stay
    while (low_chain.size() > 0 && smp < low_chain[$].value)
      void'(low_chain.pop_back());
    while (high_chain.size() > 0 && smp > high_chain[$].value)
      void'(high_chain.pop_back());
    if (low_chain.size() >= MAX_WINDOW)
      void'(low_chain.pop_front());
    if (high_chain.size() >= MAX_WINDOW)
      void'(high_chain.pop_front());
    low_chain.push_back('{value: smp, pos: now});
    high_chain.push_back('{value: smp, pos: now});
    next_pos = now + 1'b1;
    if (run_fill < MAX_WINDOW)
      run_fill++;
    if (run_fill >= span)
      expected_windows.push_back('{win_min: low_chain[0].value, win_max: high_chain[0].value});
  endtask

  task automatic queue_sample(input sample_t smp, input logic fresh);
    pending.push_back('{kind: ITEM_SAMPLE, sample: smp, fresh: fresh, len: '0});
  endtask

  task automatic queue_set_len(input len_t len);
    pending.push_back('{kind: ITEM_SET_LEN, sample: '0, fresh: 1'b0, len: len});
  endtask

  task automatic queue_drain();
    pending.push_back('{kind: ITEM_DRAIN, sample: '0, fresh: 1'b0, len: '0});
  endtask

  function automatic sample_t pick_sample(sample_style_e sty);
    sample_t v;
    case (sty)
      STY_RISE: begin
        ramp = ramp + sample_t'($urandom_range(0, 3));
        v = ramp;
      end
      STY_FALL: begin
        ramp = ramp - sample_t'($urandom_range(0, 3));
        v = ramp;
      end
      STY_NARROW: v = sample_t'($urandom_range(0, 8)) - 4;
      STY_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       v = SAMPLE_MIN;
          1:       v = SAMPLE_MAX;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      default: v = sample_t'($urandom);
    endcase
    return v;
  endfunction

  // One length setting followed by a stream of chunks, each in one style
  task automatic queue_phase(input len_t len, input int unsigned count,
                             input int unsigned fresh_odds, input bit restart,
                             input int unsigned rise_count);
    sample_style_e sty;
    int unsigned   chunk_left;
    int unsigned   i;
    logic          fresh;
    queue_set_len(len);
    chunk_left = 0;
    sty        = STY_WIDE;
    for (i = 0; i < count; i++) begin
      if (chunk_left == 0) begin
        if (i == 0 && rise_count > 0) begin
          sty        = STY_RISE;
          chunk_left = rise_count;
        end else begin
          sty        = sample_style_e'($urandom_range(0, 4));
          chunk_left = $urandom_range(8, 64);
        end
        ramp = (sty == STY_FALL) ? SAMPLE_MAX - sample_t'($urandom_range(0, 1000))
                                 : SAMPLE_MIN + sample_t'($urandom_range(0, 1000));
      end
      chunk_left--;
      fresh = (i == 0 && restart) || (fresh_odds != 0 && $urandom_range(1, fresh_odds) == 1);
      queue_sample(pick_sample(sty), fresh);
      if ($urandom_range(0, 149) == 0)
        queue_drain();
    end
  endtask

  // Source side: present queued words, write the length when idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      cfg_we_i      <= 1'b0;
      cfg_wdata_i   <= '0;
      window_reg    = 11'd1;
      gap_left      = 0;
      quiet         = 0;
      send_calm     = 1'b0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_data  = s_axis_tdata;
      nxt_user  = s_axis_tuser;
      nxt_we    = 1'b0;
      nxt_wdata = cfg_wdata_i;
      if (expected_windows.size() == 0 && !s_axis_tvalid)
        quiet++;
      else
        quiet = 0;
      // retire the accepted word and draw the gap before the next one
      if (s_axis_tvalid && s_axis_tready) begin
        advance_window(s_axis_tdata, s_axis_tuser);
        samples_sent++;
        if (s_axis_tuser)
          fresh_runs++;
        nxt_valid = 1'b0;
        if ($urandom_range(0, 49) == 0)
          send_calm = !send_calm;
        gap_left = send_calm ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          case (pending[0].kind)
            ITEM_SAMPLE: begin
              nxt_valid = 1'b1;
              nxt_data  = pending[0].sample;
              nxt_user  = pending[0].fresh;
              void'(pending.pop_front());
            end
            ITEM_SET_LEN: begin
              if (quiet >= SETTLE_CYCLES) begin
                nxt_we     = 1'b1;
                nxt_wdata  = pending[0].len;
                window_reg = pending[0].len;
                len_writes++;
                void'(pending.pop_front());
              end
            end
            default: begin
              if (quiet >= SETTLE_CYCLES)
                void'(pending.pop_front());
            end
          endcase
        end
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata  <= nxt_data;
      s_axis_tuser  <= nxt_user;
      cfg_we_i      <= nxt_we;
      cfg_wdata_i   <= nxt_wdata;
    end
  end

  // Sink side: check each result word, then stall for a drawn count
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    = 0;
      recv_calm     = 1'b0;
    end else begin
      nxt_ready = 1'b1;
      if (m_axis_tvalid && m_axis_tready) begin
        got_min = m_axis_tdata[SAMPLE_BITS-1:0];
        got_max = m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        if (expected_windows.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual min %0d max %0d",
                   $time, got_min, got_max);
          mismatches++;
        end else begin
          want = expected_windows.pop_front();
          if (got_min !== want.win_min) begin
            $display("%0t: window_min mismatch: expected %0d, actual %0d",
                     $time, want.win_min, got_min);
            mismatches++;
          end
          if (got_max !== want.win_max) begin
            $display("%0t: window_max mismatch: expected %0d, actual %0d",
                     $time, want.win_max, got_max);
            mismatches++;
          end
        end
        windows_checked++;
        if ($urandom_range(0, 49) == 0)
          recv_calm = !recv_calm;
        stall_left = recv_calm ? 0 : $urandom_range(0, GAP_MAX);
        nxt_ready  = (stall_left == 0);
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_ready = (stall_left == 0);
      end
      m_axis_tready <= nxt_ready;
    end
  end

  // Stimulus plan and end of run
  initial begin
    int k;
    // default length of one: extremes, each its own window
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b0);
    queue_sample('0, 1'b0);
    queue_sample('1, 1'b0);
    // zero length acts as one; ties and a restart
    queue_set_len('0);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b1);
    // window of three with equal samples and extremes
    queue_set_len(11'd3);
    queue_sample(sample_t'(5), 1'b1);
    queue_sample(sample_t'(5), 1'b0);
    queue_sample(sample_t'(5), 1'b0);
    queue_sample(SAMPLE_MIN, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(sample_t'(7), 1'b0);
    queue_sample(sample_t'(7), 1'b0);
    queue_sample(sample_t'(7), 1'b0);
    // shorten inside the run
    queue_set_len(11'd2);
    queue_sample(sample_t'(-9), 1'b0);
    queue_sample(sample_t'(1), 1'b0);
    queue_drain();

    // one long run: full window, oversize length, sharp shortening, position wrap
    queue_phase(11'd1024, 1100, 0, 1'b1, 1050);
    queue_phase(11'd2047, 60, 0, 1'b0, 0);
    queue_phase(11'd3, 200, 0, 1'b0, 0);
    queue_phase(11'd16, 250, 0, 1'b0, 0);
    queue_phase(11'd7, 450, 0, 1'b0, 0);
    // short windows with frequent restarts
    queue_phase(11'd1, 60, 3, 1'b0, 0);
    for (k = 0; k < 5; k++)
      queue_phase(len_t'($urandom_range(1, 40)), $urandom_range(40, 90), 30,
                  1'($urandom_range(0, 1)), 0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    while (expected_windows.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Summary: %0d samples sent, %0d of them opening a new run, %0d length writes",
             samples_sent, fresh_runs, len_writes);
    $display("Summary: %0d min/max result words compared", windows_checked);
    if (mismatches == 0 && expected_windows.size() == 0)
      $display("sliding_window_min_max verification clean");
    else
      $display("sliding_window_min_max verification failed");
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d words queued and %0d results outstanding",
             $time, pending.size(), expected_windows.size());
    $display("sliding_window_min_max verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/swmm_pkg.sv
rtl/swmm_cell.sv
rtl/swmm_chain.sv
rtl/sliding_window_min_max.sv
tb/tb_sliding_window_min_max.sv
